// ===== hw/rtl/lcdseq_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdseq_pkg: shared types and constants for the LCD bus sequencer
// Holds the request, result and setup register bundles and the codes that
// travel between the sequencer modules.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

  // Request operation codes
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_CHAR   = 3'd1;
  localparam logic [2:0] OP_SETPOS = 3'd2;
  localparam logic [2:0] OP_CMD    = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_TICK    = 2'd0;
  localparam logic [1:0] ST_OK      = 2'd1;
  localparam logic [1:0] ST_BUSY    = 2'd2;
  localparam logic [1:0] ST_BAD_POS = 2'd3;

  // Setup register indexes
  localparam logic [2:0] REG_EIGHT_BIT  = 3'd0;
  localparam logic [2:0] REG_NIBBLE_GAP = 3'd1;
  localparam logic [2:0] REG_CMD_DELAY  = 3'd2;
  localparam logic [2:0] REG_CHAR_DELAY = 3'd3;
  localparam logic [2:0] REG_CLR_DELAY  = 3'd4;

  // Setup register reset values
  localparam logic [7:0]  NIBBLE_GAP_RST = 8'd44;
  localparam logic [11:0] CMD_DELAY_RST  = 12'd40;
  localparam logic [11:0] CHAR_DELAY_RST = 12'd45;
  localparam logic [11:0] CLR_DELAY_RST  = 12'd1531;

  // Display command bytes
  localparam logic [7:0] CLEAR_CMD = 8'h01;
  localparam logic [7:0] ROW0_ADDR = 8'h80;
  localparam logic [7:0] ROW1_ADDR = 8'hC0;

  typedef struct packed {
    logic        eight_bit_bus;
    logic [7:0]  nibble_gap_us;
    logic [11:0] command_delay_us;
    logic [11:0] char_delay_us;
    logic [11:0] clear_delay_us;
  } cfg_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [1:0] row;
    logic [4:0] col;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic       pin_rs;
    logic [7:0] pin_data;
    logic       pin_enable;
    logic       busy_res;
    logic [1:0] status;
  } res_t;

endpackage

// ===== hw/rtl/lcdseq_ifs.sv =====
// ----------------------------------------------------------------------------
// lcdseq_ifs: channel interfaces of the LCD bus sequencer
// Request, result and setup write channels, each with valid/ready.
// ----------------------------------------------------------------------------
interface lcdseq_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [1:0] row;
  logic [4:0] col;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output row, output col,
                  output data_byte, input ready);
  modport sink   (input valid, input operation, input row, input col,
                  input data_byte, output ready);
endinterface

interface lcdseq_res_if;
  logic       valid;
  logic       ready;
  logic       pin_rs;
  logic [7:0] pin_data;
  logic       pin_enable;
  logic       busy_res;
  logic [1:0] status;

  modport source (output valid, output pin_rs, output pin_data, output pin_enable,
                  output busy_res, output status, input ready);
  modport sink   (input valid, input pin_rs, input pin_data, input pin_enable,
                  input busy_res, input status, output ready);
endinterface

interface lcdseq_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [11:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/char_lcd_bus_sequencer.sv =====
// ----------------------------------------------------------------------------
// char_lcd_bus_sequencer: character LCD bus timing sequencer
// Drives RS, D7..D0 and E for writes, commands, clears and cursor moves,
// timed by microsecond tick beats, in 4-bit or 8-bit bus mode.
// ----------------------------------------------------------------------------
// Result path: a result beat passes the request register, then the result
//   buffer, before it can be taken.
// Throughput: one request beat per cycle while the two-entry result buffer
//   has room or is read, keeping requests flowing through short output stalls.
// Reset (synchronous, rst high): idle bus, pins low, setup registers at
//   their defaults, buffers empty.
module char_lcd_bus_sequencer (
  input  logic         clk,
  input  logic         rst,
  lcdseq_req_if.sink   req,
  lcdseq_res_if.source res,
  lcdseq_cfg_if.sink   cfg
);

  lcdseq_pkg::cfg_t cfg_regs;
  lcdseq_pkg::req_t in_req;
  lcdseq_pkg::res_t core_res;
  lcdseq_pkg::res_t buf_res;
  logic             core_valid;
  logic             buf_valid;
  logic [1:0]       buf_count;
  logic [1:0]       occupancy;
  logic             req_fire;
  logic             res_fire;

  // setup writes are always taken
  assign cfg.ready = 1'b1;

  lcdseq_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_regs)
  );

  // request side: room in buffer counting the beat in flight
  assign occupancy = buf_count + {1'b0, core_valid};
  assign res_fire  = buf_valid && res.ready;
  assign req.ready = (occupancy < 2'd2) || res_fire;
  assign req_fire  = req.valid && req.ready;

  assign in_req.operation = req.operation;
  assign in_req.row       = req.row;
  assign in_req.col       = req.col;
  assign in_req.data_byte = req.data_byte;

  lcdseq_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req_fire),
    .in_req    (in_req),
    .cfg       (cfg_regs),
    .res_valid (core_valid),
    .res       (core_res)
  );

  lcdseq_out_fifo u_out (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (core_valid),
    .wr_data  (core_res),
    .rd_en    (res_fire),
    .rd_valid (buf_valid),
    .rd_data  (buf_res),
    .count    (buf_count)
  );

  // result side
  assign res.valid      = buf_valid;
  assign res.pin_rs     = buf_res.pin_rs;
  assign res.pin_data   = buf_res.pin_data;
  assign res.pin_enable = buf_res.pin_enable;
  assign res.busy_res   = buf_res.busy_res;
  assign res.status     = buf_res.status;

  // beats in flight never exceed the buffer depth
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    occupancy <= 2'd2)
    else $error("more beats in flight than buffer space");

endmodule

// ===== hw/rtl/lcdseq_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lcdseq_cfg_regs: setup registers
// Bus mode, nibble gap and the three post-transfer delays.
// ----------------------------------------------------------------------------
module lcdseq_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [2:0]        wr_index,
  input  logic [11:0]       wr_data,
  output lcdseq_pkg::cfg_t  cfg
);

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.eight_bit_bus    <= 1'b0;
      cfg.nibble_gap_us    <= lcdseq_pkg::NIBBLE_GAP_RST;
      cfg.command_delay_us <= lcdseq_pkg::CMD_DELAY_RST;
      cfg.char_delay_us    <= lcdseq_pkg::CHAR_DELAY_RST;
      cfg.clear_delay_us   <= lcdseq_pkg::CLR_DELAY_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        lcdseq_pkg::REG_EIGHT_BIT:  cfg.eight_bit_bus    <= wr_data[0];
        lcdseq_pkg::REG_NIBBLE_GAP: cfg.nibble_gap_us    <= wr_data[7:0];
        lcdseq_pkg::REG_CMD_DELAY:  cfg.command_delay_us <= wr_data;
        lcdseq_pkg::REG_CHAR_DELAY: cfg.char_delay_us    <= wr_data;
        lcdseq_pkg::REG_CLR_DELAY:  cfg.clear_delay_us   <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/lcdseq_core.sv =====
// ----------------------------------------------------------------------------
// lcdseq_core: request register and bus timing state
// Registers each beat, then advances the strobe phase and microsecond
// countdown in one pass and forms the pin levels and status for the beat.
// ----------------------------------------------------------------------------
module lcdseq_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  lcdseq_pkg::req_t  in_req,
  input  lcdseq_pkg::cfg_t  cfg,
  output logic              res_valid,
  output lcdseq_pkg::res_t  res
);

  // strobe phases
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_E_HI1 = 3'd1;
  localparam logic [2:0] PH_E_LO1 = 3'd2;
  localparam logic [2:0] PH_GAP   = 3'd3;
  localparam logic [2:0] PH_E_HI2 = 3'd4;
  localparam logic [2:0] PH_E_LO2 = 3'd5;
  localparam logic [2:0] PH_POST  = 3'd6;

  logic             s1_valid;
  lcdseq_pkg::req_t s1_req;

  logic [2:0]  phase, phase_next;
  logic [11:0] wait_left, wait_left_next;
  logic        held_rs, held_rs_next;
  logic [7:0]  held_byte, held_byte_next;
  logic [11:0] post_wait, post_wait_next;
  logic        rs_pin, rs_pin_next;
  logic [7:0]  data_pin, data_pin_next;
  logic        enable_pin, enable_pin_next;
  logic [1:0]  status;

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_req <= in_req;
  end

  // next state for one beat
  always_comb begin
    phase_next      = phase;
    wait_left_next  = wait_left;
    held_rs_next    = held_rs;
    held_byte_next  = held_byte;
    post_wait_next  = post_wait;
    rs_pin_next     = rs_pin;
    data_pin_next   = data_pin;
    enable_pin_next = enable_pin;
    status          = lcdseq_pkg::ST_TICK;

    if (s1_valid) begin
      if (s1_req.operation == lcdseq_pkg::OP_TICK) begin
        if (phase != PH_IDLE) begin
          if (wait_left > 12'd1) begin
            wait_left_next = wait_left - 12'd1;
          end else begin
            // step to the next phase, skipping zero-length waits
            unique case (phase)
              PH_E_HI1: begin
                phase_next      = PH_E_LO1;
                enable_pin_next = 1'b0;
                wait_left_next  = 12'd1;
              end
              PH_E_LO1, PH_GAP: begin
                enable_pin_next = 1'b0;
                if (phase == PH_E_LO1 && cfg.eight_bit_bus) begin
                  if (post_wait != 12'd0) begin
                    phase_next     = PH_POST;
                    wait_left_next = post_wait;
                  end else begin
                    phase_next     = PH_IDLE;
                    wait_left_next = 12'd0;
                  end
                end else if (phase == PH_E_LO1 && cfg.nibble_gap_us != 8'd0) begin
                  phase_next     = PH_GAP;
                  wait_left_next = {4'd0, cfg.nibble_gap_us};
                end else begin
                  phase_next      = PH_E_HI2;
                  data_pin_next   = {held_byte[3:0], 4'd0};
                  enable_pin_next = 1'b1;
                  wait_left_next  = 12'd1;
                end
              end
              PH_E_HI2: begin
                phase_next      = PH_E_LO2;
                enable_pin_next = 1'b0;
                wait_left_next  = 12'd1;
              end
              PH_E_LO2: begin
                enable_pin_next = 1'b0;
                if (post_wait != 12'd0) begin
                  phase_next     = PH_POST;
                  wait_left_next = post_wait;
                end else begin
                  phase_next     = PH_IDLE;
                  wait_left_next = 12'd0;
                end
              end
              default: begin
                phase_next      = PH_IDLE;
                wait_left_next  = 12'd0;
                enable_pin_next = 1'b0;
              end
            endcase
          end
        end
      end else if (s1_req.operation <= lcdseq_pkg::OP_CLEAR) begin
        if (phase != PH_IDLE) begin
          status = lcdseq_pkg::ST_BUSY;
        end else if (s1_req.operation == lcdseq_pkg::OP_SETPOS &&
                     (s1_req.row[1] || s1_req.col[4])) begin
          status = lcdseq_pkg::ST_BAD_POS;
        end else begin
          status = lcdseq_pkg::ST_OK;
          unique case (s1_req.operation)
            lcdseq_pkg::OP_CHAR: begin
              held_rs_next   = 1'b1;
              held_byte_next = s1_req.data_byte;
              post_wait_next = cfg.char_delay_us;
            end
            lcdseq_pkg::OP_SETPOS: begin
              held_rs_next   = 1'b0;
              held_byte_next = (s1_req.row[0] ? lcdseq_pkg::ROW1_ADDR
                                              : lcdseq_pkg::ROW0_ADDR) |
                               {4'd0, s1_req.col[3:0]};
              post_wait_next = cfg.command_delay_us;
            end
            lcdseq_pkg::OP_CMD: begin
              held_rs_next   = 1'b0;
              held_byte_next = s1_req.data_byte;
              post_wait_next = cfg.command_delay_us;
            end
            default: begin
              held_rs_next   = 1'b0;
              held_byte_next = lcdseq_pkg::CLEAR_CMD;
              post_wait_next = cfg.clear_delay_us;
            end
          endcase
          rs_pin_next     = held_rs_next;
          data_pin_next   = cfg.eight_bit_bus ? held_byte_next
                                              : {held_byte_next[7:4], 4'd0};
          phase_next      = PH_E_HI1;
          enable_pin_next = 1'b1;
          wait_left_next  = 12'd1;
        end
      end
    end
  end

  // timing state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      wait_left  <= 12'd0;
      held_rs    <= 1'b0;
      held_byte  <= 8'd0;
      post_wait  <= 12'd0;
      rs_pin     <= 1'b0;
      data_pin   <= 8'd0;
      enable_pin <= 1'b0;
    end else begin
      phase      <= phase_next;
      wait_left  <= wait_left_next;
      held_rs    <= held_rs_next;
      held_byte  <= held_byte_next;
      post_wait  <= post_wait_next;
      rs_pin     <= rs_pin_next;
      data_pin   <= data_pin_next;
      enable_pin <= enable_pin_next;
    end
  end

  // result beat, pin levels after this item
  assign res_valid      = s1_valid;
  assign res.pin_rs     = rs_pin_next;
  assign res.pin_data   = data_pin_next;
  assign res.pin_enable = enable_pin_next;
  assign res.busy_res   = (phase_next != PH_IDLE);
  assign res.status     = status;

  // idle bus has E low and no countdown pending
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (!enable_pin && wait_left == 12'd0))
    else $error("idle phase with strobe or countdown active");

  // an accepted request always starts the first strobe
  a_accept_strobe: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && status == lcdseq_pkg::ST_OK) |=> (phase == PH_E_HI1 && enable_pin))
    else $error("accepted request did not raise E");

endmodule

// ===== hw/rtl/lcdseq_out_fifo.sv =====
// ----------------------------------------------------------------------------
// lcdseq_out_fifo: two-entry result buffer
// Holds result beats so requests keep flowing while the sink stalls.
// ----------------------------------------------------------------------------
module lcdseq_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  lcdseq_pkg::res_t  wr_data,
  input  logic              rd_en,
  output logic              rd_valid,
  output lcdseq_pkg::res_t  rd_data,
  output logic [1:0]        count
);

  lcdseq_pkg::res_t mem [2];
  logic             wr_ptr;
  logic             rd_ptr;

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  assign rd_valid = (count != 2'd0);
  assign rd_data  = mem[rd_ptr];

  // never write into a full buffer without a read
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && count == 2'd2 && !rd_en))
    else $error("result buffer overflow");

endmodule

// ===== sim/char_lcd_bus_sequencer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_bus_sequencer_test: self-checking bench for the LCD bus sequencer
// Starts with a directed table that covers reset state, rejects, zero-length
// steps and a mode switch during a transfer. It then runs random request and
// tick beats under a series of setup register settings. Each result beat is
// compared with a cycle-free predictor of the pin sequencer.
// ----------------------------------------------------------------------------
module char_lcd_bus_sequencer_test;

  localparam int LIMIT_CYCLES = 600000;

  // Bus sequencer steps; one past the post wait falls back to idle
  localparam logic [2:0] BS_IDLE    = 3'd0;
  localparam logic [2:0] BS_E_HIGH  = 3'd1;
  localparam logic [2:0] BS_E_LOW   = 3'd2;
  localparam logic [2:0] BS_GAP     = 3'd3;
  localparam logic [2:0] BS_E2_HIGH = 3'd4;
  localparam logic [2:0] BS_E2_LOW  = 3'd5;
  localparam logic [2:0] BS_POST    = 3'd6;

  // Operation codes and register indexes with no function
  localparam logic [2:0] OP_SPARE_FIRST  = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST   = 3'd7;
  localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

  typedef struct {
    bit                is_cfg;
    logic [2:0]        reg_idx;
    logic [11:0]       reg_val;
    lcdseq_pkg::req_t  r;
    bit                known;
    lcdseq_pkg::res_t  want;
  } dir_row_t;

  typedef struct {
    int eight;
    int gap;
    int cmd;
    int chr;
    int clr;
    int items;
    bit flush;
    bit burst;
  } run_phase_t;

  logic clk = 1'b0;
  logic rst;

  lcdseq_req_if req_ch ();
  lcdseq_res_if res_ch ();
  lcdseq_cfg_if cfg_ch ();

  char_lcd_bus_sequencer dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  always #5 clk = ~clk;

  // Setup register shadow
  logic        sh_eight_bit = 1'b0;
  logic [7:0]  sh_gap_us    = lcdseq_pkg::NIBBLE_GAP_RST;
  logic [11:0] sh_cmd_us    = lcdseq_pkg::CMD_DELAY_RST;
  logic [11:0] sh_char_us   = lcdseq_pkg::CHAR_DELAY_RST;
  logic [11:0] sh_clear_us  = lcdseq_pkg::CLR_DELAY_RST;

  // Predicted sequencer state
  logic [2:0]  bus_step  = BS_IDLE;
  logic [12:0] us_left   = '0;
  logic        held_rs   = 1'b0;
  logic [7:0]  held_byte = '0;
  logic [12:0] held_post = '0;
  logic        rs_pin    = 1'b0;
  logic [7:0]  data_pin  = '0;
  logic        en_pin    = 1'b0;

  lcdseq_pkg::res_t pending_results[$];
  bit   no_idle    = 1'b0;
  int   fail_count = 0;
  int   cycle_count = 0;

  // Enter a step, falling through steps of zero length
  task automatic enter_step(input logic [2:0] first);
    logic [2:0] s;
    bit         done;
    s    = first;
    done = 1'b0;
    while (!done) begin
      bus_step = s;
      done     = 1'b1;
      unique case (s)
        BS_E_HIGH: begin
          en_pin = 1'b1; us_left = 13'd1;
        end
        BS_E_LOW: begin
          en_pin = 1'b0; us_left = 13'd1;
        end
        BS_GAP: begin
          if (sh_eight_bit) begin
            s = BS_POST; done = 1'b0;
          end else begin
            en_pin  = 1'b0;
            us_left = {5'd0, sh_gap_us};
            if (us_left == '0) begin
              s = BS_E2_HIGH; done = 1'b0;
            end
          end
        end
        BS_E2_HIGH: begin
          data_pin = {held_byte[3:0], 4'h0};
          en_pin   = 1'b1; us_left = 13'd1;
        end
        BS_E2_LOW: begin
          en_pin = 1'b0; us_left = 13'd1;
        end
        BS_POST: begin
          en_pin  = 1'b0;
          us_left = held_post;
          if (us_left == '0) begin
            s = BS_IDLE; done = 1'b0;
          end
        end
        default: begin
          bus_step = BS_IDLE; us_left = '0; en_pin = 1'b0;
        end
      endcase
    end
  endtask

  // Advance the predicted pins by one beat and form the expected result
  task automatic predict_bus(input lcdseq_pkg::req_t r, output lcdseq_pkg::res_t want);
    logic [1:0] st;
    st = lcdseq_pkg::ST_TICK;
    if (r.operation == lcdseq_pkg::OP_TICK) begin
      if (bus_step != BS_IDLE) begin
        if (us_left > 13'd1) us_left = us_left - 13'd1;
        else enter_step(bus_step + 3'd1);
      end
    end else if (r.operation <= lcdseq_pkg::OP_CLEAR) begin
      if (bus_step != BS_IDLE) begin
        st = lcdseq_pkg::ST_BUSY;
      end else if (r.operation == lcdseq_pkg::OP_SETPOS &&
                   (r.row > 2'd1 || r.col > 5'd15)) begin
        st = lcdseq_pkg::ST_BAD_POS;
      end else begin
        st = lcdseq_pkg::ST_OK;
        unique case (r.operation)
          lcdseq_pkg::OP_CHAR: begin
            held_rs = 1'b1; held_byte = r.data_byte; held_post = {1'b0, sh_char_us};
          end
          lcdseq_pkg::OP_SETPOS: begin
            held_rs   = 1'b0;
            held_byte = ((r.row == 2'd0) ? lcdseq_pkg::ROW0_ADDR : lcdseq_pkg::ROW1_ADDR) |
                        {3'b000, r.col};
            held_post = {1'b0, sh_cmd_us};
          end
          lcdseq_pkg::OP_CMD: begin
            held_rs = 1'b0; held_byte = r.data_byte; held_post = {1'b0, sh_cmd_us};
          end
          default: begin
            held_rs   = 1'b0;
            held_byte = lcdseq_pkg::CLEAR_CMD;
            held_post = {1'b0, sh_clear_us};
          end
        endcase
        rs_pin   = held_rs;
        data_pin = sh_eight_bit ? held_byte : {held_byte[7:4], 4'h0};
        enter_step(BS_E_HIGH);
      end
    end
    want.pin_rs     = rs_pin;
    want.pin_data   = data_pin;
    want.pin_enable = en_pin;
    want.busy_res   = (bus_step != BS_IDLE);
    want.status     = st;
  endtask

  function automatic int draw_gap();
    return no_idle ? 0 : int'($urandom_range(0, 11));
  endfunction

  // Send one request beat; the expectation is queued when it is taken
  task automatic send_item(input lcdseq_pkg::req_t r, input bit known,
                           input lcdseq_pkg::res_t typed_want);
    lcdseq_pkg::res_t want;
    int               gap;
    gap = draw_gap();
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid     = 1'b1;
    req_ch.operation = r.operation;
    req_ch.row       = r.row;
    req_ch.col       = r.col;
    req_ch.data_byte = r.data_byte;
    do @(posedge clk); while (!req_ch.ready);
    predict_bus(r, want);
    pending_results.push_back(known ? typed_want : want);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    do @(posedge clk); while (!cfg_ch.ready);
    unique case (idx)
      lcdseq_pkg::REG_EIGHT_BIT:  sh_eight_bit = val[0];
      lcdseq_pkg::REG_NIBBLE_GAP: sh_gap_us    = val[7:0];
      lcdseq_pkg::REG_CMD_DELAY:  sh_cmd_us    = val;
      lcdseq_pkg::REG_CHAR_DELAY: sh_char_us   = val;
      lcdseq_pkg::REG_CLR_DELAY:  sh_clear_us  = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Stop requests and wait until every expected beat has come back
  task automatic settle();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic dir_row_t row_req(input logic [2:0] op, input logic [1:0] row,
                                       input logic [4:0] col, input logic [7:0] b);
    dir_row_t d;
    d.is_cfg = 1'b0; d.reg_idx = '0; d.reg_val = '0; d.known = 1'b0; d.want = '0;
    d.r.operation = op; d.r.row = row; d.r.col = col; d.r.data_byte = b;
    return d;
  endfunction

  function automatic dir_row_t row_chk(input dir_row_t d, input logic rs,
                                       input logic [7:0] pins, input logic en,
                                       input logic busy, input logic [1:0] st);
    dir_row_t o;
    o = d;
    o.known = 1'b1;
    o.want.pin_rs = rs; o.want.pin_data = pins; o.want.pin_enable = en;
    o.want.busy_res = busy; o.want.status = st;
    return o;
  endfunction

  function automatic dir_row_t row_cfg(input logic [2:0] idx, input logic [11:0] val);
    dir_row_t d;
    d = row_req(lcdseq_pkg::OP_TICK, 2'd0, 5'd0, 8'd0);
    d.is_cfg = 1'b1; d.reg_idx = idx; d.reg_val = val;
    return d;
  endfunction

  // Result side: random stalls, each beat checked against the oldest expectation
  initial begin
    int               stall;
    lcdseq_pkg::res_t want;
    res_ch.ready = 1'b0;
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        @(negedge clk);
        res_ch.ready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      res_ch.ready = 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (res_ch.pin_rs !== want.pin_rs) begin
          $error("pin_rs: expected %0d, got %0d", want.pin_rs, res_ch.pin_rs);
          fail_count++;
        end
        if (res_ch.pin_data !== want.pin_data) begin
          $error("pin_data: expected %0h, got %0h", want.pin_data, res_ch.pin_data);
          fail_count++;
        end
        if (res_ch.pin_enable !== want.pin_enable) begin
          $error("pin_enable: expected %0d, got %0d", want.pin_enable, res_ch.pin_enable);
          fail_count++;
        end
        if (res_ch.busy_res !== want.busy_res) begin
          $error("busy_res: expected %0d, got %0d", want.busy_res, res_ch.busy_res);
          fail_count++;
        end
        if (res_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_ch.status);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Stimulus
  initial begin
    dir_row_t         dir_rows[$];
    run_phase_t       phases[7];
    run_phase_t       ph;
    lcdseq_pkg::req_t r;
    int               pick;

    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.operation = lcdseq_pkg::OP_TICK;
    req_ch.row       = '0;
    req_ch.col       = '0;
    req_ch.data_byte = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = lcdseq_pkg::REG_EIGHT_BIT;
    cfg_ch.data      = '0;

    // Directed table: request and tick beats with setup writes between them
    dir_rows = '{
      row_chk(row_req(lcdseq_pkg::OP_TICK, 2'd0, 5'd0, 8'h00),
              1'b0, 8'h00, 1'b0, 1'b0, lcdseq_pkg::ST_TICK),
      row_chk(row_req(OP_SPARE_FIRST, 2'd3, 5'd31, 8'hFF),
              1'b0, 8'h00, 1'b0, 1'b0, lcdseq_pkg::ST_TICK),
      row_chk(row_req(OP_SPARE_LAST, 2'd3, 5'd31, 8'hFF),
              1'b0, 8'h00, 1'b0, 1'b0, lcdseq_pkg::ST_TICK),
      row_chk(row_req(lcdseq_pkg::OP_SETPOS, 2'd2, 5'd0, 8'h00),
              1'b0, 8'h00, 1'b0, 1'b0, lcdseq_pkg::ST_BAD_POS),
      row_chk(row_req(lcdseq_pkg::OP_SETPOS, 2'd0, 5'd16, 8'h00),
              1'b0, 8'h00, 1'b0, 1'b0, lcdseq_pkg::ST_BAD_POS),
      row_cfg(lcdseq_pkg::REG_NIBBLE_GAP, 12'd0),
      row_cfg(lcdseq_pkg::REG_CMD_DELAY, 12'd0),
      row_cfg(lcdseq_pkg::REG_CHAR_DELAY, 12'd0),
      row_chk(row_req(lcdseq_pkg::OP_SETPOS, 2'd1, 5'd15, 8'h00),
              1'b0, 8'hC0, 1'b1, 1'b1, lcdseq_pkg::ST_OK),
      row_chk(row_req(lcdseq_pkg::OP_CHAR, 2'd0, 5'd0, 8'hFF),
              1'b0, 8'hC0, 1'b1, 1'b1, lcdseq_pkg::ST_BUSY),
      row_chk(row_req(lcdseq_pkg::OP_SETPOS, 2'd3, 5'd31, 8'h00),
              1'b0, 8'hC0, 1'b1, 1'b1, lcdseq_pkg::ST_BUSY),
      row_chk(row_req(lcdseq_pkg::OP_TICK, 2'd0, 5'd0, 8'h00),
              1'b0, 8'hC0, 1'b0, 1'b1, lcdseq_pkg::ST_TICK),
      // zero gap: second nibble strobe starts at once
      row_chk(row_req(lcdseq_pkg::OP_TICK, 2'd0, 5'd0, 8'h00),
              1'b0, 8'hF0, 1'b1, 1'b1, lcdseq_pkg::ST_TICK),
      row_chk(row_req(lcdseq_pkg::OP_TICK, 2'd0, 5'd0, 8'h00),
              1'b0, 8'hF0, 1'b0, 1'b1, lcdseq_pkg::ST_TICK),
      // zero post wait: back to idle on the same tick
      row_chk(row_req(lcdseq_pkg::OP_TICK, 2'd0, 5'd0, 8'h00),
              1'b0, 8'hF0, 1'b0, 1'b0, lcdseq_pkg::ST_TICK),
      row_chk(row_req(lcdseq_pkg::OP_CHAR, 2'd0, 5'd0, 8'hA5),
              1'b1, 8'hA0, 1'b1, 1'b1, lcdseq_pkg::ST_OK),
      row_chk(row_req(lcdseq_pkg::OP_TICK, 2'd0, 5'd0, 8'h00),
              1'b1, 8'hA0, 1'b0, 1'b1, lcdseq_pkg::ST_TICK),
      // bus mode switched between the strobes of a transfer
      row_cfg(lcdseq_pkg::REG_EIGHT_BIT, 12'd1),
      row_req(lcdseq_pkg::OP_TICK, 2'd0, 5'd0, 8'h00),
      row_chk(row_req(lcdseq_pkg::OP_CMD, 2'd0, 5'd0, 8'h3C),
              1'b0, 8'h3C, 1'b1, 1'b1, lcdseq_pkg::ST_OK),
      row_req(lcdseq_pkg::OP_TICK, 2'd0, 5'd0, 8'h00),
      row_req(lcdseq_pkg::OP_TICK, 2'd0, 5'd0, 8'h00),
      row_cfg(lcdseq_pkg::REG_CLR_DELAY, 12'd2),
      row_chk(row_req(lcdseq_pkg::OP_CLEAR, 2'd0, 5'd0, 8'h00),
              1'b0, lcdseq_pkg::CLEAR_CMD, 1'b1, 1'b1, lcdseq_pkg::ST_OK),
      row_req(lcdseq_pkg::OP_TICK, 2'd0, 5'd0, 8'h00),
      row_req(lcdseq_pkg::OP_TICK, 2'd0, 5'd0, 8'h00),
      row_chk(row_req(lcdseq_pkg::OP_CHAR, 2'd0, 5'd0, 8'h00),
              1'b0, lcdseq_pkg::CLEAR_CMD, 1'b0, 1'b1, lcdseq_pkg::ST_BUSY),
      row_req(lcdseq_pkg::OP_TICK, 2'd0, 5'd0, 8'h00),
      row_req(lcdseq_pkg::OP_TICK, 2'd0, 5'd0, 8'h00)
    };

    // eight, gap, cmd, char, clear, items, flush, burst
    phases = '{
      '{0, 44, 40, 45, 60, 70, 1'b1, 1'b0},
      '{1, 0, 0, 0, 0, 70, 1'b0, 1'b0},
      '{0, 0, 0, 0, 0, 70, 1'b0, 1'b0},
      '{0, 255, 40, 20, 100, 50, 1'b1, 1'b0},
      '{0, 3, 5, 2, 9, 90, 1'b0, 1'b1},
      '{1, 255, 7, 1, 12, 50, 1'b0, 1'b0},
      '{0, 1, 1, 3, 1, 80, 1'b1, 1'b0}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) begin
        settle();
        write_reg(dir_rows[k].reg_idx, dir_rows[k].reg_val);
      end else begin
        send_item(dir_rows[k].r, dir_rows[k].known, dir_rows[k].want);
      end
    end

    // Random part, one setup per phase; a phase may end mid-transfer
    foreach (phases[p]) begin
      ph = phases[p];
      settle();
      no_idle = ph.burst;
      write_reg(lcdseq_pkg::REG_EIGHT_BIT, {11'($urandom), 1'(ph.eight)});
      write_reg(lcdseq_pkg::REG_NIBBLE_GAP, {4'($urandom), 8'(ph.gap)});
      write_reg(lcdseq_pkg::REG_CMD_DELAY, 12'(ph.cmd));
      write_reg(lcdseq_pkg::REG_CHAR_DELAY, 12'(ph.chr));
      write_reg(lcdseq_pkg::REG_CLR_DELAY, 12'(ph.clr));
      write_reg(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), 12'($urandom));

      repeat (ph.items) begin
        r.row       = 2'($urandom_range(0, 3));
        r.col       = 5'($urandom_range(0, 31));
        r.data_byte = 8'($urandom_range(0, 255));
        if (bus_step != BS_IDLE && $urandom_range(0, 99) < 85) begin
          r.operation = lcdseq_pkg::OP_TICK;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 12)      r.operation = lcdseq_pkg::OP_TICK;
          else if (pick < 40) r.operation = lcdseq_pkg::OP_CHAR;
          else if (pick < 62) r.operation = lcdseq_pkg::OP_SETPOS;
          else if (pick < 82) r.operation = lcdseq_pkg::OP_CMD;
          else if (pick < 90) r.operation = lcdseq_pkg::OP_CLEAR;
          else r.operation = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        end
        // most position requests are in range
        if (r.operation == lcdseq_pkg::OP_SETPOS && $urandom_range(0, 99) < 75) begin
          r.row = 2'($urandom_range(0, 1));
          r.col = 5'($urandom_range(0, 15));
        end
        send_item(r, 1'b0, '0);
      end

      // run the transfer out at full rate
      if (ph.flush) begin
        no_idle = 1'b1;
        while (bus_step != BS_IDLE) begin
          r.operation = lcdseq_pkg::OP_TICK;
          r.row       = 2'($urandom_range(0, 3));
          r.col       = 5'($urandom_range(0, 31));
          r.data_byte = 8'($urandom_range(0, 255));
          send_item(r, 1'b0, '0);
        end
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/lcdseq_pkg.sv
hw/rtl/lcdseq_ifs.sv
hw/rtl/lcdseq_cfg_regs.sv
hw/rtl/lcdseq_core.sv
hw/rtl/lcdseq_out_fifo.sv
hw/rtl/char_lcd_bus_sequencer.sv
sim/char_lcd_bus_sequencer_test.sv
